@@ design/wndc_pkg.sv @@
// Shared types, widths and constants for the window neighbor density block.
package wndc_pkg;

	// Field widths
	localparam int POS_W   = 24;
	localparam int READ_W  = 16;
	localparam int RAD_W   = 16;
	localparam int CONF_W  = 7;
	localparam int COUNT_W = 7;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// Default history depth and register reset values
	localparam int WINDOW_DEF = 50;
	localparam logic [RAD_W-1:0] RADIUS_X_RST = 16'd384;
	localparam logic [RAD_W-1:0] RADIUS_Y_RST = 16'd15;

	// Percent scale
	localparam int PERCENT = 100;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 8'd1;

	typedef struct packed {
		logic signed [POS_W-1:0] position_x;
		logic [READ_W-1:0]       ceiling_reading;
	} in_t;

	typedef struct packed {
		logic [CONF_W-1:0]  confidence;
		logic [COUNT_W-1:0] neighbor_count;
	} out_t;

endpackage

@@ design/window_neighbor_density_confidence.sv @@
// Top level: history memory, scan sequencer and confidence scaling.
//
//  Channel | Signals                          | Beat
//  --------+----------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data      | one sensor point
//  out     | out_valid, out_ready, out_data   | confidence and neighbor count
//  cfg     | cfg_valid, cfg_ready, cfg_index, | one register write
//          | cfg_data                         |
//
// Per point, from accept to result: the single comparator reads one history
// entry per scan cycle from the memory for each of the fill points held (fill
// at most WINDOW; the scan is skipped with an empty history), ST_LAST drains the
// memory read register, ST_MUL1 and ST_MUL2 scale, and ST_DONE loads the output.
// in_ready is high only while the sequencer is idle; a result waiting in the
// output register does not block the next accept, only the next result.
// Reset clears the fill count and write slot and loads the radii reset values;
// history is read only where written. cfg writes are always taken.
module window_neighbor_density_confidence
	import wndc_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int ENT_W  = POS_W + READ_W;
	// Product count*100 stays below 2^13
	localparam int PROD_W = 13;
	// Reciprocal of WINDOW, exact for every product below 2^PROD_W
	localparam int RECIP_SH = PROD_W + 7;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam logic [RECIP_W-1:0] RECIP_M =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
	localparam int QF_W = PROD_W + RECIP_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_MUL1,
		ST_MUL2,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [RAD_W-1:0]        radius_x_q;
	logic [RAD_W-1:0]        radius_y_q;
	logic signed [POS_W-1:0] pos_q;
	logic [READ_W-1:0]       read_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        slot_q;
	logic [FILL_W-1:0]       fill_q;
	logic [COUNT_W-1:0]      count_q;
	logic [PROD_W-1:0]       prod_q;
	logic [CONF_W-1:0]       conf_q;
	logic                    out_valid_q;
	out_t                    out_data_q;

	logic [ENT_W-1:0] mem_q [WINDOW];
	logic [ENT_W-1:0] rd_s1;
	logic             cmp_valid_s1;
	logic             hit;
	logic             mem_we;
	logic             in_acc;
	logic [QF_W-1:0]  quot_full;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign mem_we    = (state_q == ST_MUL1);
	assign quot_full = QF_W'(prod_q) * QF_W'(RECIP_M);

	// Hold the radii
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_x_q <= RADIUS_X_RST;
			radius_y_q <= RADIUS_Y_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RADIUS_X: radius_x_q <= cfg_data;
				CFG_RADIUS_Y: radius_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// History memory: write the new point, read one entry per scan cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[slot_q] <= {pos_q, read_q};
		end
		rd_s1 <= mem_q[idx_q];
	end

	wndc_near u_near (
		.cur_pos   (pos_q),
		.cur_read  (read_q),
		.hist_pos  (rd_s1[ENT_W-1:READ_W]),
		.hist_read (rd_s1[READ_W-1:0]),
		.radius_x  (radius_x_q),
		.radius_y  (radius_y_q),
		.hit       (hit)
	);

	// Sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			slot_q       <= '0;
			fill_q       <= '0;
			count_q      <= '0;
			cmp_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// Load a new result, or drop the one just taken
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Count a neighbor for each compared entry that hits
			if (cmp_valid_s1 && hit) begin
				count_q <= count_q + COUNT_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					cmp_valid_s1 <= 1'b0;
					if (in_acc) begin
						count_q <= '0;
						idx_q   <= '0;
						state_q <= (fill_q == '0) ? ST_MUL1 : ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_valid_s1 <= 1'b1;
					if (FILL_W'(idx_q) + FILL_W'(1) == fill_q) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_LAST: begin
					cmp_valid_s1 <= 1'b0;
					state_q      <= ST_MUL1;
				end
				ST_MUL1: begin
					// Append the point and advance the slot
					if (slot_q == IDX_W'(WINDOW - 1)) begin
						slot_q <= '0;
					end else begin
						slot_q <= slot_q + IDX_W'(1);
					end
					if (fill_q != FILL_W'(WINDOW)) begin
						fill_q <= fill_q + FILL_W'(1);
					end
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: latch the point, scale the count, load the result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_q  <= in_data.position_x;
			read_q <= in_data.ceiling_reading;
		end
		if (state_q == ST_MUL1) begin
			prod_q <= PROD_W'(14'(count_q) * 14'(PERCENT));
		end
		if (state_q == ST_MUL2) begin
			conf_q <= quot_full[RECIP_SH +: CONF_W];
		end
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_data_q.confidence     <= conf_q;
			out_data_q.neighbor_count <= count_q;
		end
	end

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW))
		else $error("fill count above window");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(slot_q) < WINDOW)
		else $error("write slot out of range");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		FILL_W'(count_q) <= fill_q || count_q == COUNT_W'(0))
		else $error("neighbor count above fill count");

	a_conf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.confidence <= CONF_W'(PERCENT))
		else $error("confidence above 100");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready held after accept");
`endif

endmodule

@@ design/wndc_near.sv @@
// Neighborhood test: one stored point against the current point.
module wndc_near
	import wndc_pkg::*;
(
	input  logic signed [POS_W-1:0] cur_pos,
	input  logic [READ_W-1:0]       cur_read,
	input  logic signed [POS_W-1:0] hist_pos,
	input  logic [READ_W-1:0]       hist_read,
	input  logic [RAD_W-1:0]        radius_x,
	input  logic [RAD_W-1:0]        radius_y,
	output logic                    hit
);

	logic signed [POS_W:0] pos_diff;
	logic [POS_W:0]        pos_abs;
	logic signed [READ_W:0] read_diff;
	logic [READ_W:0]        read_abs;

	// Form distances at full precision
	always_comb begin
		pos_diff  = {hist_pos[POS_W-1], hist_pos} - {cur_pos[POS_W-1], cur_pos};
		pos_abs   = pos_diff[POS_W] ? (POS_W+1)'(-pos_diff) : pos_diff;
		read_diff = $signed({1'b0, hist_read}) - $signed({1'b0, cur_read});
		read_abs  = read_diff[READ_W] ? (READ_W+1)'(-read_diff) : read_diff;
	end

	// Both bounds inclusive
	assign hit = (pos_abs <= (POS_W+1)'(radius_x)) && (read_abs <= (READ_W+1)'(radius_y));

endmodule
